### hdl/mvm_pkg.sv
// Package for the matrix-vector multiply block: sizes, codes and payload types.
// No dependencies; imported by matrix_vector_multiply.
`default_nettype none

package mvm_pkg;

   // store and element sizing
   localparam int VECTOR_DEPTH  = 4096;
   localparam int ELEMENT_WIDTH = 16;
   localparam int COL_W         = $clog2(VECTOR_DEPTH);
   localparam int INDEX_W       = 12;
   localparam int PROD_W        = 2 * ELEMENT_WIDTH;
   localparam int SUM_W         = 48;

   // register field widths and reset values
   localparam int ROW_LEN_W        = 13;
   localparam int ROW_CNT_W        = 16;
   localparam int ROW_LENGTH_RESET = 4096;
   localparam int ROW_COUNT_RESET  = 1;

   // compare widths with room for a count plus one
   localparam int LEN_CMP_W = ((COL_W > ROW_LEN_W) ? COL_W : ROW_LEN_W) + 1;
   localparam int ROW_CMP_W = ROW_CNT_W + 1;

   // result buffer
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // register port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_STREAM = 1'b1
   } cmd_type;

   // register index, taken from address bit 2
   typedef enum logic {
      REG_ROW_LENGTH = 1'b0,
      REG_ROW_COUNT  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                            cmd;
      logic [INDEX_W-1:0]              element_index;
      logic signed [ELEMENT_WIDTH-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] row_sum;
      logic [ROW_CNT_W-1:0]    row_number;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/matrix_vector_multiply.sv
// Matrix-vector multiply top level: vector store memory, multiply-accumulate pipeline,
// result buffer and register port. Depends on mvm_pkg.
//
// Usage: first load the vector with req transfers of cmd load (element_index picks the
// store entry), then stream the matrix in row-major order with cmd stream. Every
// row_length streamed elements give one rsp transfer carrying the row sum and the row
// number; the row number wraps to zero after row_count rows. Entries must be loaded
// before they are used: the store is not cleared by reset.
// Throughput: one req transfer per cycle while req_ready is high, loads and elements.
// Result path: at the edge that takes a row's last element the store is read into a
// register with the element, then the product is registered, then the sum is
// accumulated into the buffer and rsp_valid rises.
// Stalls: up to 4 row results wait in an output buffer; req_ready falls only while
// 4 results are pending, so a stalled receiver holds up the input after 4 rows.
// Reset: row_length returns to 4096, row_count to 1, the sum and the column and row
// counters to zero, and the buffer empties.
// Registers: row_length at byte address 0, row_count at byte address 4; write only
// while the block is idle.
`default_nettype none

module matrix_vector_multiply (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input channel
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire mvm_pkg::req_type            req_payload,
   // result channel
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      mvm_pkg::rsp_type            rsp_payload,
   // register port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [mvm_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [mvm_pkg::CSR_DW-1:0]  csr_pwdata,
   output      logic [mvm_pkg::CSR_DW-1:0]  csr_prdata,
   output      logic                        csr_pready
);
   import mvm_pkg::*;

   // configuration registers
   logic [ROW_LEN_W-1:0] row_length_ff;
   logic [ROW_CNT_W-1:0] row_count_ff;
   logic                 csr_write;
   reg_index_type        csr_index;

   // front end counters
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic [LEN_CMP_W-1:0] len_eff;
   logic [ROW_CMP_W-1:0] cnt_eff;
   logic                 col_last, row_wrap;
   logic                 req_xfer, stream_acc, load_acc, load_in_range;
   logic [COL_W-1:0]     load_addr;

   // vector store
   logic [ELEMENT_WIDTH-1:0] vec_mem [VECTOR_DEPTH];
   logic signed [ELEMENT_WIDTH-1:0] rd_data_ff;

   // stage 1: store data ready
   logic                            s1_valid_ff, s1_last_ff;
   logic [ROW_CNT_W-1:0]            s1_row_ff;
   logic signed [ELEMENT_WIDTH-1:0] s1_value_ff;
   logic signed [PROD_W-1:0]        prod_in;

   // stage 2: product ready
   logic                     s2_valid_ff, s2_last_ff;
   logic [ROW_CNT_W-1:0]     s2_row_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in, acc_sum;

   // result buffer
   rsp_type              fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]     fifo_count_ff, fifo_count_in;
   logic [FIFO_AW:0]     outstanding_ff, outstanding_in;
   logic                 fifo_push, rsp_xfer, result_acc;

   // register write decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LEN_W'(ROW_LENGTH_RESET);
         row_count_ff  <= ROW_CNT_W'(ROW_COUNT_RESET);
      end else if (csr_write) begin
         case (csr_index)
            REG_ROW_LENGTH: row_length_ff <= csr_pwdata[ROW_LEN_W-1:0];
            REG_ROW_COUNT:  row_count_ff  <= csr_pwdata[ROW_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (csr_index)
         REG_ROW_LENGTH: csr_prdata = CSR_DW'(row_length_ff);
         REG_ROW_COUNT:  csr_prdata = CSR_DW'(row_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // input transfer classification
   assign req_ready  = outstanding_ff < (FIFO_AW+1)'(FIFO_DEPTH);
   assign req_xfer   = req_valid & req_ready;
   assign stream_acc = req_xfer & (req_payload.cmd == CMD_STREAM);
   assign load_acc   = req_xfer & (req_payload.cmd == CMD_LOAD);

   // effective row length and row count after clamping
   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = LEN_CMP_W'(1);
      end else if (LEN_CMP_W'(row_length_ff) > LEN_CMP_W'(VECTOR_DEPTH)) begin
         len_eff = LEN_CMP_W'(VECTOR_DEPTH);
      end else begin
         len_eff = LEN_CMP_W'(row_length_ff);
      end
      cnt_eff = (row_count_ff == '0) ? ROW_CMP_W'(1) : ROW_CMP_W'(row_count_ff);
   end

   // end of row and row wrap decisions
   assign col_last = (LEN_CMP_W'(col_ff) + 1'b1) >= len_eff;
   assign row_wrap = (ROW_CMP_W'(row_ff) + 1'b1) >= cnt_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (stream_acc) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // vector store: loads write, matrix elements read their column
   assign load_addr     = COL_W'(req_payload.element_index);
   assign load_in_range = LEN_CMP_W'(req_payload.element_index) < LEN_CMP_W'(VECTOR_DEPTH);

   always_ff @(posedge clock) begin
      if (load_acc && load_in_range) begin
         vec_mem[load_addr] <= req_payload.element_value;
      end
      if (stream_acc) begin
         rd_data_ff <= vec_mem[col_ff];
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= stream_acc;
      end
      if (stream_acc) begin
         s1_last_ff  <= col_last;
         s1_row_ff   <= row_ff;
         s1_value_ff <= req_payload.element_value;
      end
   end

   // multiply
   assign prod_in = s1_value_ff * rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_last_ff <= s1_last_ff;
         s2_row_ff  <= s1_row_ff;
         prod_ff    <= prod_in;
      end
   end

   // accumulate, clear after the last column
   assign acc_sum   = sum_ff + SUM_W'(prod_ff);
   assign fifo_push = s2_valid_ff & s2_last_ff;

   always_comb begin
      sum_in = sum_ff;
      if (s2_valid_ff) begin
         sum_in = s2_last_ff ? '0 : acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // result buffer storage
   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem[wr_ptr_ff] <= '{row_sum: acc_sum, row_number: s2_row_ff};
      end
   end

   assign rsp_valid   = fifo_count_ff != '0;
   assign rsp_payload = fifo_mem[rd_ptr_ff];
   assign rsp_xfer    = rsp_valid & rsp_ready;
   assign result_acc  = stream_acc & col_last;

   // buffer occupancy and results promised to the buffer
   always_comb begin
      fifo_count_in  = fifo_count_ff;
      outstanding_in = outstanding_ff;
      case ({fifo_push, rsp_xfer})
         2'b10:   fifo_count_in = fifo_count_ff + 1'b1;
         2'b01:   fifo_count_in = fifo_count_ff - 1'b1;
         default: fifo_count_in = fifo_count_ff;
      endcase
      case ({result_acc, rsp_xfer})
         2'b10:   outstanding_in = outstanding_ff + 1'b1;
         2'b01:   outstanding_in = outstanding_ff - 1'b1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fifo_count_ff  <= '0;
         outstanding_ff <= '0;
      end else begin
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_count_ff  <= fifo_count_in;
         outstanding_ff <= outstanding_in;
      end
   end

   // pending results never exceed buffer space
   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("pending results exceed buffer depth");

   // buffer holds only results already counted as pending
   a_fifo_within_outstanding: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= outstanding_ff)
      else $error("buffer holds more than pending count");

   // no push into a full buffer unless a result drains in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_count_ff != (FIFO_AW+1)'(FIFO_DEPTH)) || rsp_xfer)
      else $error("result buffer overflow");

   // end of row taken with no drain raises the pending count
   a_pending_grows: assert property (@(posedge clock) disable iff (reset)
      (result_acc && !rsp_xfer) |=> outstanding_ff == $past(outstanding_ff) + 1'b1)
      else $error("pending count missed a row result");

   // a row end that is taken passes stage 1 and stage 2 and reaches the accumulator as a push
   a_row_end_reaches_sum: assert property (@(posedge clock) disable iff (reset)
      result_acc |-> ##2 fifo_push)
      else $error("row end lost in pipeline");

endmodule

`default_nettype wire
